### rtl/ehp_pkg.sv
// Shared types, constants and field helpers for the Ethernet/IPv4/ARP header parser.
package ehp_pkg;

    // Header layout, in bytes from the start of the frame
    localparam int unsigned CapLen = 42;
    localparam int unsigned EthLen = 14;
    localparam int unsigned IpEnd  = 34;
    localparam int unsigned ArpMin = 18;
    localparam int unsigned ArpEnd = 42;

    localparam int unsigned PosWidth = 6;
    localparam int unsigned SumWidth = 20;

    localparam logic [15:0] EtypeIpv4  = 16'h0800;
    localparam logic [15:0] EtypeArp   = 16'h0806;
    localparam logic [15:0] SumAllOnes = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_ETH       = 3'd0,
        KIND_IPV4      = 3'd1,
        KIND_ARP_IPV4  = 3'd2,
        KIND_ARP_OTHER = 3'd3,
        KIND_UNSUPP    = 3'd4,
        KIND_TRUNC     = 3'd5
    } kind_t;

    // Captured header bytes, entry 0 is the first byte on the wire
    typedef logic [CapLen-1:0][7:0] cap_t;

    // Frame snapshot handed from the capture unit to the record builder
    typedef struct packed {
        logic [PosWidth-1:0] count;
        logic [SumWidth-1:0] sum;
        cap_t                cap;
    } view_t;

    typedef struct packed {
        kind_t       kind;
        logic [47:0] mac_first;
        logic [47:0] mac_second;
        logic [31:0] addr_first;
        logic [31:0] addr_second;
        logic [15:0] type_word;
        logic [15:0] ident_or_opcode;
        logic [7:0]  version_and_length;
        logic [15:0] fragment_word;
        logic        checksum_good;
        logic [15:0] ttl_and_protocol;
        logic        last_record;
    } rec_t;

    typedef struct packed {
        logic two;
        rec_t rec0;
        rec_t rec1;
    } pair_t;

    // Big-endian field extraction from the capture
    function automatic logic [15:0] be16(cap_t c, logic [PosWidth-1:0] start);
        return {c[start], c[start + 6'd1]};
    endfunction

    function automatic logic [31:0] be32(cap_t c, logic [PosWidth-1:0] start);
        return {be16(c, start), be16(c, start + 6'd2)};
    endfunction

    function automatic logic [47:0] be48(cap_t c, logic [PosWidth-1:0] start);
        return {be16(c, start), be32(c, start + 6'd2)};
    endfunction

endpackage

### rtl/ethernet_ipv4_arp_header_parser.sv
// Top level of the Ethernet/IPv4/ARP header parser.
// Throughput: one frame byte per cycle; a byte that ends a frame waits in the input register
//   while the output stage holds two records, or holds one that is stalled.
// The last byte passes the input register, then the first record loads the output register;
//   the second record follows in the cycle after the first is taken.
// Reset: rst_n clears position, header sum and valid flags; captured bytes and payload are not.
module ethernet_ipv4_arp_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        record_valid,
    input  logic        record_stall,
    output logic [2:0]  record_kind,
    output logic [47:0] mac_first,
    output logic [47:0] mac_second,
    output logic [31:0] addr_first,
    output logic [31:0] addr_second,
    output logic [15:0] type_word,
    output logic [15:0] ident_or_opcode,
    output logic [7:0]  version_and_length,
    output logic [15:0] fragment_word,
    output logic        checksum_good,
    output logic [15:0] ttl_and_protocol,
    output logic        last_record
);

    logic           in_valid_reg;
    logic [7:0]     byte_reg;
    logic           end_reg;
    logic           take;
    logic           step;
    ehp_pkg::view_t view;
    ehp_pkg::pair_t pair;
    ehp_pkg::rec_t  rec;

    // Hold the input register while a frame end cannot hand off its records
    assign frame_stall = in_valid_reg && end_reg && !take;
    assign step        = in_valid_reg && !frame_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!frame_stall)
            in_valid_reg <= frame_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!frame_stall)
        begin
            byte_reg <= frame_byte;
            end_reg  <= frame_end;
        end
    end

    ehp_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .frame_byte (byte_reg),
        .frame_end  (end_reg),
        .view       (view)
    );

    ehp_record u_record (
        .view (view),
        .pair (pair)
    );

    ehp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && end_reg),
        .pair      (pair),
        .take      (take),
        .out_valid (record_valid),
        .out_stall (record_stall),
        .out_rec   (rec)
    );

    assign record_kind        = rec.kind;
    assign mac_first          = rec.mac_first;
    assign mac_second         = rec.mac_second;
    assign addr_first         = rec.addr_first;
    assign addr_second        = rec.addr_second;
    assign type_word          = rec.type_word;
    assign ident_or_opcode    = rec.ident_or_opcode;
    assign version_and_length = rec.version_and_length;
    assign fragment_word      = rec.fragment_word;
    assign checksum_good      = rec.checksum_good;
    assign ttl_and_protocol   = rec.ttl_and_protocol;
    assign last_record        = rec.last_record;

endmodule

### rtl/ehp_capture.sv
// Byte capture, position count and running header sum for one frame.
module ehp_capture (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        frame_byte,
    input  logic              frame_end,
    output ehp_pkg::view_t    view
);

    logic [ehp_pkg::PosWidth-1:0] pos_reg;
    logic [ehp_pkg::PosWidth-1:0] pos_next;
    logic [ehp_pkg::SumWidth-1:0] sum_reg;
    logic [ehp_pkg::SumWidth-1:0] sum_next;
    logic [7:0]                   hold_reg;
    logic [7:0]                   hold_next;
    ehp_pkg::cap_t                cap_reg;
    ehp_pkg::cap_t                cap_next;
    logic                         in_cap;
    logic                         in_sum;

    assign in_cap = pos_reg < ehp_pkg::PosWidth'(ehp_pkg::CapLen);
    assign in_sum = (pos_reg >= ehp_pkg::PosWidth'(ehp_pkg::EthLen)) &&
                    (pos_reg < ehp_pkg::PosWidth'(ehp_pkg::IpEnd));

    // Write decode: each entry is loaded only at its own position
    always_comb
    begin
        for (int i = 0; i < ehp_pkg::CapLen; i++)
        begin
            if (step && pos_reg == ehp_pkg::PosWidth'(i))
                cap_next[i] = frame_byte;
            else
                cap_next[i] = cap_reg[i];
        end
    end

    // Position and ones'-complement sum, high byte on even offsets
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hold_next = hold_reg;
        if (step)
        begin
            if (in_sum)
            begin
                if (!pos_reg[0])
                    hold_next = frame_byte;
                else
                    sum_next = sum_reg + ehp_pkg::SumWidth'({hold_reg, frame_byte});
            end
            if (in_cap)
                pos_next = pos_reg + 6'd1;
        end
    end

    assign view.count = pos_next;
    assign view.sum   = sum_next;
    assign view.cap   = cap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            hold_reg <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
            if (step && frame_end)
            begin
                pos_reg <= '0;
                sum_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end
        end
    end

    // Header bytes carry no reset
    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
    end

endmodule

### rtl/ehp_record.sv
// Builds the Ethernet record and the network-layer record from a frame snapshot.
module ehp_record (
    input  ehp_pkg::view_t view,
    output ehp_pkg::pair_t pair
);

    logic [15:0]   etype;
    logic [15:0]   ptype;
    logic [16:0]   fold1;
    logic [15:0]   fold2;
    ehp_pkg::rec_t eth;
    ehp_pkg::rec_t net;
    ehp_pkg::rec_t trunc;

    assign etype = ehp_pkg::be16(view.cap, 6'd12);
    assign ptype = ehp_pkg::be16(view.cap, 6'd16);

    // Fold the 20-bit sum twice into 16 bits
    assign fold1 = {1'b0, view.sum[15:0]} + 17'(view.sum[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        trunc             = '0;
        trunc.kind        = ehp_pkg::KIND_TRUNC;
        trunc.last_record = 1'b1;

        eth            = '0;
        eth.kind       = ehp_pkg::KIND_ETH;
        eth.mac_first  = ehp_pkg::be48(view.cap, 6'd0);
        eth.mac_second = ehp_pkg::be48(view.cap, 6'd6);
        eth.type_word  = etype;

        net             = '0;
        net.last_record = 1'b1;
        if (etype == ehp_pkg::EtypeIpv4)
        begin
            if (view.count < ehp_pkg::PosWidth'(ehp_pkg::IpEnd))
                net = trunc;
            else
            begin
                net.kind               = ehp_pkg::KIND_IPV4;
                net.addr_first         = ehp_pkg::be32(view.cap, 6'd26);
                net.addr_second        = ehp_pkg::be32(view.cap, 6'd30);
                net.type_word          = ehp_pkg::be16(view.cap, 6'd16);
                net.ident_or_opcode    = ehp_pkg::be16(view.cap, 6'd18);
                net.version_and_length = view.cap[14];
                net.fragment_word      = ehp_pkg::be16(view.cap, 6'd20);
                net.checksum_good      = fold2 == ehp_pkg::SumAllOnes;
                net.ttl_and_protocol   = ehp_pkg::be16(view.cap, 6'd22);
            end
        end
        else if (etype == ehp_pkg::EtypeArp)
        begin
            if (view.count < ehp_pkg::PosWidth'(ehp_pkg::ArpMin))
                net = trunc;
            else if (ptype == ehp_pkg::EtypeIpv4)
            begin
                if (view.count < ehp_pkg::PosWidth'(ehp_pkg::ArpEnd))
                    net = trunc;
                else
                begin
                    net.kind            = ehp_pkg::KIND_ARP_IPV4;
                    net.mac_first       = ehp_pkg::be48(view.cap, 6'd22);
                    net.mac_second      = ehp_pkg::be48(view.cap, 6'd32);
                    net.addr_first      = ehp_pkg::be32(view.cap, 6'd28);
                    net.addr_second     = ehp_pkg::be32(view.cap, 6'd38);
                    net.type_word       = ehp_pkg::be16(view.cap, 6'd14);
                    net.ident_or_opcode = ehp_pkg::be16(view.cap, 6'd20);
                end
            end
            else
            begin
                net.kind            = ehp_pkg::KIND_ARP_OTHER;
                net.type_word       = ehp_pkg::be16(view.cap, 6'd14);
                net.ident_or_opcode = ptype;
            end
        end
        else
            net.kind = ehp_pkg::KIND_UNSUPP;

        // Frame too short for Ethernet: a single truncated record
        if (view.count < ehp_pkg::PosWidth'(ehp_pkg::EthLen))
        begin
            pair.two  = 1'b0;
            pair.rec0 = trunc;
            pair.rec1 = trunc;
        end
        else
        begin
            pair.two  = 1'b1;
            pair.rec0 = eth;
            pair.rec1 = net;
        end
    end

endmodule

### rtl/ehp_out.sv
// Two-entry output stage: result register plus a slot for the second record.
module ehp_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ehp_pkg::pair_t pair,
    output logic           take,
    output logic           out_valid,
    input  logic           out_stall,
    output ehp_pkg::rec_t  out_rec
);

    logic          valid_reg;
    logic          slot1_valid_reg;
    ehp_pkg::rec_t slot0_reg;
    ehp_pkg::rec_t slot1_reg;
    logic          pop;

    // Room for a full pair once the second slot is empty and the head is empty or leaves
    assign pop       = valid_reg && !out_stall;
    assign take      = !slot1_valid_reg && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_rec   = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            slot1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg       <= 1'b1;
            slot1_valid_reg <= pair.two;
        end
        else if (pop)
        begin
            valid_reg       <= slot1_valid_reg;
            slot1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= pair.rec0;
            slot1_reg <= pair.rec1;
        end
        else if (pop)
            slot0_reg <= slot1_reg;
    end

endmodule

### rtl/ehp_checker.sv
// Port-level checks for the header parser, bound to the top level.
module ehp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        frame_valid,
    input logic        frame_stall,
    input logic [7:0]  frame_byte,
    input logic        frame_end,
    input logic        record_valid,
    input logic        record_stall,
    input logic [2:0]  record_kind,
    input logic [47:0] mac_first,
    input logic [47:0] mac_second,
    input logic [31:0] addr_first,
    input logic [31:0] addr_second,
    input logic [15:0] type_word,
    input logic [15:0] ident_or_opcode,
    input logic [7:0]  version_and_length,
    input logic [15:0] fragment_word,
    input logic        checksum_good,
    input logic [15:0] ttl_and_protocol,
    input logic        last_record
);

    // A stalled byte stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(frame_byte) &&
        $stable(frame_end))
        else $error("stalled frame byte changed");

    // A stalled record stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && record_stall |=> record_valid && $stable(record_kind) &&
        $stable(mac_first) && $stable(mac_second) && $stable(addr_first) &&
        $stable(addr_second) && $stable(type_word) && $stable(ident_or_opcode) &&
        $stable(version_and_length) && $stable(fragment_word) &&
        $stable(checksum_good) && $stable(ttl_and_protocol) && $stable(last_record))
        else $error("stalled record changed");

    // An Ethernet record is always followed by its network-layer record
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_stall && !last_record |=> record_valid)
        else $error("network record missing after ethernet record");

    // Only the Ethernet record leaves a frame's run open
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> ((record_kind == ehp_pkg::KIND_ETH) != last_record))
        else $error("last_record does not match record kind");

    // Input is only held back while a record is waiting
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> record_valid)
        else $error("input stalled with no record pending");

endmodule

bind ethernet_ipv4_arp_header_parser ehp_checker u_ehp_checker (.*);

### dv/ehp_record_compare.sv
// Record predictor and comparator for the Ethernet/IPv4/ARP header parser testbench.
`timescale 1ns / 100ps
module ehp_record_compare (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    input  logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic        record_valid,
    input  logic        record_stall,
    input  logic [2:0]  record_kind,
    input  logic [47:0] mac_first,
    input  logic [47:0] mac_second,
    input  logic [31:0] addr_first,
    input  logic [31:0] addr_second,
    input  logic [15:0] type_word,
    input  logic [15:0] ident_or_opcode,
    input  logic [7:0]  version_and_length,
    input  logic [15:0] fragment_word,
    input  logic        checksum_good,
    input  logic [15:0] ttl_and_protocol,
    input  logic        last_record,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    // Predicted parser state
    logic [7:0]                   hdr_bytes [ehp_pkg::CapLen];
    int unsigned                  byte_pos;
    logic [ehp_pkg::SumWidth-1:0] hdr_sum;
    logic [7:0]                   hi_byte;

    ehp_pkg::rec_t expected_recs [$];
    ehp_pkg::rec_t got;
    ehp_pkg::rec_t want;

    // Big-endian value of len captured bytes starting at start
    function automatic logic [63:0] hdr_value(int unsigned start, int unsigned len);
        logic [63:0] v;
        v = '0;
        for (int unsigned i = 0; i < len; i++)
        begin
            v = {v[55:0], hdr_bytes[start + i]};
        end
        return v;
    endfunction

    function automatic ehp_pkg::rec_t blank_rec(ehp_pkg::kind_t kind, logic last);
        ehp_pkg::rec_t r;
        r = '0;
        r.kind = kind;
        r.last_record = last;
        return r;
    endfunction

    function automatic string rec_text(ehp_pkg::rec_t r);
        return $sformatf({"kind=%0d mac=%h/%h ip=%h/%h type=%h id=%h vl=%h frag=%h ",
                          "ck=%b tp=%h last=%b"},
                         r.kind, r.mac_first, r.mac_second, r.addr_first, r.addr_second,
                         r.type_word, r.ident_or_opcode, r.version_and_length,
                         r.fragment_word, r.checksum_good, r.ttl_and_protocol,
                         r.last_record);
    endfunction

    // Advance the prediction by one frame byte; queue the records a final byte causes
    task automatic take_byte(logic [7:0] b, logic last);
        int unsigned   count;
        logic [15:0]   etype;
        logic [15:0]   ptype;
        logic [31:0]   folded;
        ehp_pkg::rec_t eth;
        ehp_pkg::rec_t net;
        if (byte_pos < ehp_pkg::CapLen)
            hdr_bytes[byte_pos] = b;
        // checksum words of the fixed 20-byte IPv4 header
        if (byte_pos >= ehp_pkg::EthLen && byte_pos < ehp_pkg::IpEnd)
        begin
            if (((byte_pos - ehp_pkg::EthLen) % 2) == 0)
                hi_byte = b;
            else
                hdr_sum = hdr_sum + ehp_pkg::SumWidth'({hi_byte, b});
        end
        if (byte_pos < ehp_pkg::CapLen)
            byte_pos++;
        if (!last)
            return;

        count    = byte_pos;
        folded   = 32'(hdr_sum);
        byte_pos = 0;
        hdr_sum  = '0;

        if (count < ehp_pkg::EthLen)
        begin
            expected_recs.push_back(blank_rec(ehp_pkg::KIND_TRUNC, 1'b1));
            return;
        end

        etype = 16'(hdr_value(12, 2));
        eth = blank_rec(ehp_pkg::KIND_ETH, 1'b0);
        eth.mac_first  = 48'(hdr_value(0, 6));
        eth.mac_second = 48'(hdr_value(6, 6));
        eth.type_word  = etype;
        expected_recs.push_back(eth);

        net = blank_rec(ehp_pkg::KIND_UNSUPP, 1'b1);
        if (etype == ehp_pkg::EtypeIpv4)
        begin
            if (count < ehp_pkg::IpEnd)
                net.kind = ehp_pkg::KIND_TRUNC;
            else
            begin
                folded = (folded >> 16) + (folded & 32'hFFFF);
                folded = folded + (folded >> 16);
                net.kind               = ehp_pkg::KIND_IPV4;
                net.addr_first         = 32'(hdr_value(26, 4));
                net.addr_second        = 32'(hdr_value(30, 4));
                net.type_word          = 16'(hdr_value(16, 2));
                net.ident_or_opcode    = 16'(hdr_value(18, 2));
                net.version_and_length = hdr_bytes[14];
                net.fragment_word      = 16'(hdr_value(20, 2));
                net.checksum_good      = (folded[15:0] == ehp_pkg::SumAllOnes);
                net.ttl_and_protocol   = 16'(hdr_value(22, 2));
            end
        end
        else if (etype == ehp_pkg::EtypeArp)
        begin
            if (count < ehp_pkg::ArpMin)
                net.kind = ehp_pkg::KIND_TRUNC;
            else
            begin
                ptype = 16'(hdr_value(16, 2));
                if (ptype != ehp_pkg::EtypeIpv4)
                begin
                    net.kind            = ehp_pkg::KIND_ARP_OTHER;
                    net.type_word       = 16'(hdr_value(14, 2));
                    net.ident_or_opcode = ptype;
                end
                else if (count < ehp_pkg::ArpEnd)
                    net.kind = ehp_pkg::KIND_TRUNC;
                else
                begin
                    net.kind            = ehp_pkg::KIND_ARP_IPV4;
                    net.mac_first       = 48'(hdr_value(22, 6));
                    net.mac_second      = 48'(hdr_value(32, 6));
                    net.addr_first      = 32'(hdr_value(28, 4));
                    net.addr_second     = 32'(hdr_value(38, 4));
                    net.type_word       = 16'(hdr_value(14, 2));
                    net.ident_or_opcode = 16'(hdr_value(20, 2));
                end
            end
        end
        expected_recs.push_back(net);
    endtask

    // Predict on each byte transaction, compare on each record transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos = 0;
            hdr_sum  = '0;
            hi_byte  = '0;
            expected_recs.delete();
            pending  = 0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
                take_byte(frame_byte, frame_end);
            if (record_valid && !record_stall)
            begin
                got.kind               = ehp_pkg::kind_t'(record_kind);
                got.mac_first          = mac_first;
                got.mac_second         = mac_second;
                got.addr_first         = addr_first;
                got.addr_second        = addr_second;
                got.type_word          = type_word;
                got.ident_or_opcode    = ident_or_opcode;
                got.version_and_length = version_and_length;
                got.fragment_word      = fragment_word;
                got.checksum_good      = checksum_good;
                got.ttl_and_protocol   = ttl_and_protocol;
                got.last_record        = last_record;
                checked++;
                if (expected_recs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb: unexpected record at %0t: %s", $realtime, rec_text(got));
                end
                else
                begin
                    want = expected_recs.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("tb: record %0d mismatch at %0t", checked, $realtime);
                            $display("  expected %s", rec_text(want));
                            $display("  actual   %s", rec_text(got));
                        end
                    end
                end
            end
            pending = expected_recs.size();
        end
    end

endmodule

### dv/tb_ethernet_ipv4_arp_header_parser.sv
// Testbench top for the Ethernet/IPv4/ARP header parser: frame stimulus, record sink, verdict.
`timescale 1ns / 100ps
module tb_ethernet_ipv4_arp_header_parser;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    localparam int RandomBytes      = 850;
    localparam int HoldoffCycles    = 500;
    localparam int HoldAfterRecords = 30;
    localparam int WatchdogLimit    = 4000;
    localparam int MaxFrame         = 128;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        frame_valid  = 1'b0;
    logic        frame_stall;
    logic [7:0]  frame_byte   = 8'h00;
    logic        frame_end    = 1'b0;
    logic        record_valid;
    logic        record_stall = 1'b1;
    logic [2:0]  record_kind;
    logic [47:0] mac_first;
    logic [47:0] mac_second;
    logic [31:0] addr_first;
    logic [31:0] addr_second;
    logic [15:0] type_word;
    logic [15:0] ident_or_opcode;
    logic [7:0]  version_and_length;
    logic [15:0] fragment_word;
    logic        checksum_good;
    logic [15:0] ttl_and_protocol;
    logic        last_record;

    int fail_count;
    int pending;
    int checked;

    logic [7:0] frame_buf [MaxFrame];
    int         frame_len;
    int         frames_sent;
    int         bytes_sent;
    int         idle_cycles;
    int         records_taken;
    bit         held_off;
    bit         sink_quiet;

    ethernet_ipv4_arp_header_parser u_top (.*);

    ehp_record_compare u_compare (.*);

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (record_valid && !record_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb: no transaction for %0d cycles", WatchdogLimit);
            $display("tb: failure");
            $finish;
        end
    end

    // Record sink: random hold-off before each record, one long hold-off
    initial
    begin : record_sink
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && records_taken == HoldAfterRecords)
            begin
                held_off = 1'b1;
                n = HoldoffCycles;
            end
            else
            begin
                if (records_taken % 16 == 0)
                    sink_quiet = ($urandom_range(0, 3) == 0);
                n = sink_quiet ? 0 : $urandom_range(0, 9);
            end
            if (n > 0)
            begin
                record_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            record_stall <= 1'b0;
            do @(posedge clk); while (!(record_valid && !record_stall));
            records_taken++;
        end
    end

    // Fill the frame buffer and place the ethertype
    task automatic lay_frame(int len, logic [15:0] etype, fill_t fill);
        for (int i = 0; i < MaxFrame; i++)
        begin
            case (fill)
                FILL_ZERO: frame_buf[i] = 8'h00;
                FILL_ONES: frame_buf[i] = 8'hFF;
                default:   frame_buf[i] = 8'($urandom_range(0, 255));
            endcase
        end
        frame_buf[12] = etype[15:8];
        frame_buf[13] = etype[7:0];
        frame_len = len;
    endtask

    // Write a correct header checksum over the 20-byte IPv4 base header
    task automatic seal_ipv4_sum();
        logic [31:0] acc;
        acc = 0;
        frame_buf[24] = 8'h00;
        frame_buf[25] = 8'h00;
        for (int i = ehp_pkg::EthLen; i < ehp_pkg::IpEnd; i += 2)
        begin
            acc = acc + 32'({frame_buf[i], frame_buf[i + 1]});
        end
        acc = (acc >> 16) + (acc & 32'hFFFF);
        acc = acc + (acc >> 16);
        frame_buf[24] = ~acc[15:8];
        frame_buf[25] = ~acc[7:0];
    endtask

    // Stream the buffered frame; quiet means no gaps between bytes
    task automatic send_frame(bit quiet);
        int gap;
        for (int i = 0; i < frame_len; i++)
        begin
            gap = quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                frame_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            frame_valid <= 1'b1;
            frame_byte  <= frame_buf[i];
            frame_end   <= (i == frame_len - 1);
            do @(posedge clk); while (frame_stall);
        end
        frames_sent++;
        bytes_sent += frame_len;
    endtask

    // Stop sending until every predicted record has come out
    task automatic drain_records();
        frame_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin : frame_source
        int pick;
        int target;
        wait (rst_n);
        @(posedge clk);

        // Directed frames: truncation at each boundary, checksum extremes, long frame
        lay_frame(1, ehp_pkg::EtypeIpv4, FILL_ONES);
        send_frame(1'b0);
        lay_frame(ehp_pkg::EthLen - 1, ehp_pkg::EtypeIpv4, FILL_ZERO);
        send_frame(1'b1);
        lay_frame(ehp_pkg::EthLen, ehp_pkg::EtypeIpv4, FILL_ONES);
        send_frame(1'b0);
        lay_frame(ehp_pkg::IpEnd - 1, ehp_pkg::EtypeIpv4, FILL_RANDOM);
        send_frame(1'b1);
        lay_frame(ehp_pkg::IpEnd, ehp_pkg::EtypeIpv4, FILL_ONES);
        seal_ipv4_sum();
        send_frame(1'b0);
        lay_frame(ehp_pkg::IpEnd, ehp_pkg::EtypeIpv4, FILL_ZERO);
        seal_ipv4_sum();
        frame_buf[25] = frame_buf[25] ^ 8'h01;
        send_frame(1'b1);
        // header-length nibble past 20 bytes: checksum still over the base header
        lay_frame(60, ehp_pkg::EtypeIpv4, FILL_RANDOM);
        frame_buf[14] = 8'h4F;
        seal_ipv4_sum();
        send_frame(1'b0);
        lay_frame(ehp_pkg::ArpMin - 1, ehp_pkg::EtypeArp, FILL_ONES);
        send_frame(1'b1);
        lay_frame(ehp_pkg::ArpMin, ehp_pkg::EtypeArp, FILL_RANDOM);
        frame_buf[16] = 8'h86;
        frame_buf[17] = 8'hDD;
        send_frame(1'b0);
        lay_frame(ehp_pkg::ArpEnd - 1, ehp_pkg::EtypeArp, FILL_ONES);
        {frame_buf[16], frame_buf[17]} = ehp_pkg::EtypeIpv4;
        send_frame(1'b1);
        lay_frame(ehp_pkg::ArpEnd, ehp_pkg::EtypeArp, FILL_ZERO);
        {frame_buf[16], frame_buf[17]} = ehp_pkg::EtypeIpv4;
        send_frame(1'b0);
        lay_frame(ehp_pkg::ArpEnd, ehp_pkg::EtypeArp, FILL_ONES);
        {frame_buf[16], frame_buf[17]} = ehp_pkg::EtypeIpv4;
        send_frame(1'b1);
        lay_frame(ehp_pkg::EthLen, 16'h0000, FILL_ZERO);
        send_frame(1'b0);
        lay_frame(ehp_pkg::EthLen, 16'hFFFF, FILL_ONES);
        send_frame(1'b1);
        lay_frame(120, ehp_pkg::EtypeIpv4, FILL_RANDOM);
        seal_ipv4_sum();
        send_frame(1'b0);
        drain_records();

        // Random traffic, mostly well-formed IPv4 and ARP headers
        target = bytes_sent + RandomBytes;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                lay_frame($urandom_range(ehp_pkg::IpEnd, 64), ehp_pkg::EtypeIpv4, FILL_RANDOM);
                if ($urandom_range(0, 4) != 0)
                    frame_buf[14] = 8'h45;
                if ($urandom_range(0, 3) != 0)
                    seal_ipv4_sum();
            end
            else if (pick < 45)
                lay_frame($urandom_range(ehp_pkg::EthLen, ehp_pkg::IpEnd - 1),
                          ehp_pkg::EtypeIpv4, FILL_RANDOM);
            else if (pick < 70)
            begin
                lay_frame($urandom_range(ehp_pkg::ArpEnd, 64), ehp_pkg::EtypeArp, FILL_RANDOM);
                if ($urandom_range(0, 3) != 0)
                    {frame_buf[14], frame_buf[15]} = 16'h0001;
                {frame_buf[16], frame_buf[17]} = ehp_pkg::EtypeIpv4;
                {frame_buf[20], frame_buf[21]} = 16'($urandom_range(1, 2));
            end
            else if (pick < 76)
            begin
                lay_frame($urandom_range(ehp_pkg::EthLen, ehp_pkg::ArpEnd - 1),
                          ehp_pkg::EtypeArp, FILL_RANDOM);
                {frame_buf[16], frame_buf[17]} = ehp_pkg::EtypeIpv4;
            end
            else if (pick < 85)
                lay_frame($urandom_range(ehp_pkg::ArpMin, 64), ehp_pkg::EtypeArp, FILL_RANDOM);
            else if (pick < 94)
                lay_frame($urandom_range(ehp_pkg::EthLen, 64), 16'($urandom_range(0, 65535)),
                          FILL_RANDOM);
            else
                lay_frame($urandom_range(1, ehp_pkg::EthLen - 1), ehp_pkg::EtypeIpv4,
                          FILL_RANDOM);
            // occasional frame well past the captured header
            if (frame_len >= ehp_pkg::IpEnd && $urandom_range(0, 19) == 0)
                frame_len = $urandom_range(65, MaxFrame - 1);
            send_frame($urandom_range(0, 3) == 0);
            if (frames_sent % 12 == 0)
                drain_records();
        end

        drain_records();
        repeat (20) @(negedge clk);
        $display("tb: %0d frames, %0d bytes: boundary cases, then random IPv4, ARP and other",
                 frames_sent, bytes_sent);
        $display("tb: %0d records compared, %0d mismatches, with long output hold-off and drains",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
